// ===== rtl/bb3_pkg.sv =====
`timescale 1ns / 1ps

package bb3_pkg;

  // Configuration port
  localparam int CFG_W       = 11;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_BIT = 2;

  // Pixel data
  localparam int PIX_W       = 32;
  localparam int RGB_W       = 24;
  localparam int CH_W        = 8;
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SH    = 16;
  localparam int OUT_COORD_W = 10;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // Reciprocals scaled by 2^RECIP_SH, exact for every sum a window can give
  localparam logic [RECIP_W-1:0] RECIP_4 = 15'd16384;
  localparam logic [RECIP_W-1:0] RECIP_6 = 15'd10923;
  localparam logic [RECIP_W-1:0] RECIP_9 = 15'd7282;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  // Number of in-frame pixels in the neighbourhood
  typedef enum logic [1:0] {
    DIV4 = 2'd0,
    DIV6 = 2'd1,
    DIV9 = 2'd2
  } div_e;

  // Per-channel window sums, index 2 red, 1 green, 0 blue
  typedef logic [2:0][SUM_W-1:0] sums_t;

  // Position and edge flags of the blurred pixel an item produces
  typedef struct packed {
    logic                   produce;
    logic                   last;
    logic                   row_top;
    logic                   row_bot;
    logic                   col_left;
    logic                   col_right;
    logic [OUT_COORD_W-1:0] col;
    logic [OUT_COORD_W-1:0] row;
  } pos_t;

  function automatic logic [RECIP_W-1:0] recip(input div_e d);
    logic [RECIP_W-1:0] r;
    case (d)
      DIV4:    r = RECIP_4;
      DIV6:    r = RECIP_6;
      DIV9:    r = RECIP_9;
      default: r = RECIP_4;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/bb3_ram.sv =====
`timescale 1ns / 1ps

module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bb3_cfg.sv =====
`timescale 1ns / 1ps

module bb3_cfg #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int DIM_W  = $clog2(MAX_WIDTH + 1),
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bb3_pkg::PADDR_W-1:0]  paddr,
  input  logic [bb3_pkg::PDATA_W-1:0]  pwdata,
  output logic [bb3_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic                         restart_o,
  output logic [DIM_W-1:0]             width_o,
  output logic [HDIM_W-1:0]            height_o
);

  import bb3_pkg::*;

  logic [CFG_W-1:0] width_q, width_d;
  logic [CFG_W-1:0] height_q, height_d;
  logic             wr;
  reg_idx_e         idx;
  logic [31:0]      width_full, height_full;

  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign idx       = reg_idx_e'(paddr[REG_IDX_BIT]);
  assign restart_o = wr;

  // Decode register writes
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr) begin
      case (idx)
        REG_FRAME_WIDTH:  width_d  = pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: height_d = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(800);
      height_q <= CFG_W'(600);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Read back the stored bits
  always_comb begin
    case (idx)
      REG_FRAME_WIDTH:  prdata = PDATA_W'(width_q);
      REG_FRAME_HEIGHT: prdata = PDATA_W'(height_q);
      default:          prdata = '0;
    endcase
  end

  // Saturate the dimensions in use
  always_comb begin
    if (width_q < CFG_W'(2)) begin
      width_full = 32'd2;
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      width_full = 32'(MAX_WIDTH);
    end else begin
      width_full = 32'(width_q);
    end
    if (height_q < CFG_W'(2)) begin
      height_full = 32'd2;
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      height_full = 32'(MAX_HEIGHT);
    end else begin
      height_full = 32'(height_q);
    end
  end

  assign width_o  = width_full[DIM_W-1:0];
  assign height_o = height_full[HDIM_W-1:0];

endmodule

// ===== rtl/bb3_scan.sv =====
`timescale 1ns / 1ps

module bb3_scan #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int COL_W  = $clog2(MAX_WIDTH),
  localparam int DIM_W  = $clog2(MAX_WIDTH + 1),
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1),
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 2)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              restart_i,
  input  logic              step_i,
  input  logic              kind_i,
  input  logic [DIM_W-1:0]  width_i,
  input  logic [HDIM_W-1:0] height_i,
  output logic              process_o,
  output logic [COL_W-1:0]  col_o,
  output bb3_pkg::pos_t     pos_o
);

  import bb3_pkg::*;

  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic [DIM_W-1:0] col_ext, col_inc, ocol;
  logic [ROW_W-1:0] h_ext, orow;
  logic             drain, first;
  logic [31:0]      ocol_full, orow_full;

  assign col_ext = DIM_W'(in_col_q);
  assign col_inc = col_ext + DIM_W'(1);
  assign h_ext   = ROW_W'(height_i);
  assign first   = (in_col_q == '0);

  // Drain rows take flush ticks only, the frame proper takes pixels only
  assign drain     = (in_row_q >= h_ext);
  assign process_o = kind_i ? drain : !drain;
  assign col_o     = in_col_q;

  // Centre of the window the item completes
  assign ocol = first ? (width_i - DIM_W'(1)) : (col_ext - DIM_W'(1));
  assign orow = first ? (in_row_q - ROW_W'(2)) : (in_row_q - ROW_W'(1));
  assign ocol_full = 32'(ocol);
  assign orow_full = 32'(orow);

  always_comb begin
    pos_o.produce   = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && !first);
    pos_o.last      = first && (in_row_q == h_ext + ROW_W'(1));
    pos_o.row_top   = (orow != '0);
    pos_o.row_bot   = (orow < h_ext - ROW_W'(1));
    pos_o.col_left  = (ocol != '0);
    pos_o.col_right = (ocol < width_i - DIM_W'(1));
    pos_o.col       = ocol_full[OUT_COORD_W-1:0];
    pos_o.row       = orow_full[OUT_COORD_W-1:0];
  end

  // Advance the raster position, restart after the last drain tick or on a register write
  always_comb begin
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    if (restart_i) begin
      in_col_d = '0;
      in_row_d = '0;
    end else if (step_i && process_o) begin
      if (pos_o.last) begin
        in_col_d = '0;
        in_row_d = '0;
      end else if (col_inc >= width_i) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
      end else begin
        in_col_d = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
    end else begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
    end
  end

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_ext < width_i)
    else $error("column counter beyond frame width");

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && process_o && pos_o.last |=> (in_col_q == '0) && (in_row_q == '0))
    else $error("frame did not restart after its last pixel");

endmodule

// ===== rtl/bb3_window.sv =====
`timescale 1ns / 1ps

module bb3_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       shift_i,
  input  logic [bb3_pkg::RGB_W-1:0]  top_i,
  input  logic [bb3_pkg::RGB_W-1:0]  mid_i,
  input  logic [bb3_pkg::RGB_W-1:0]  bot_i,
  input  bb3_pkg::pos_t              pos_i,
  output bb3_pkg::sums_t             sums_o,
  output bb3_pkg::div_e              div_o
);

  import bb3_pkg::*;

  logic [RGB_W-1:0] win_q [9];
  logic [2:0]       row_ok, col_ok;

  // Shift the window left and load the new column on the right
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_i) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]     <= win_q[r*3 + 1];
        win_q[r*3 + 1] <= win_q[r*3 + 2];
      end
      win_q[2] <= top_i;
      win_q[5] <= mid_i;
      win_q[8] <= bot_i;
    end
  end

  assign row_ok = {pos_i.row_bot, 1'b1, pos_i.row_top};
  assign col_ok = {pos_i.col_right, 1'b1, pos_i.col_left};

  // Sum the in-frame taps per channel, row by row
  always_comb begin
    logic [SUM_W-1:0] row_sum;
    logic [SUM_W-1:0] total;
    sums_o = '0;
    for (int ch = 0; ch < 3; ch++) begin
      total = '0;
      for (int r = 0; r < 3; r++) begin
        row_sum = '0;
        for (int c = 0; c < 3; c++) begin
          if (col_ok[c]) begin
            row_sum = row_sum + SUM_W'(win_q[r*3 + c][ch*CH_W +: CH_W]);
          end
        end
        if (row_ok[r]) begin
          total = total + row_sum;
        end
      end
      sums_o[ch] = total;
    end
  end

  // Pick the divisor from the edge flags
  always_comb begin
    if (pos_i.row_top && pos_i.row_bot && pos_i.col_left && pos_i.col_right) begin
      div_o = DIV9;
    end else if ((pos_i.row_top && pos_i.row_bot) || (pos_i.col_left && pos_i.col_right)) begin
      div_o = DIV6;
    end else begin
      div_o = DIV4;
    end
  end

endmodule

// ===== rtl/bb3_norm.sv =====
`timescale 1ns / 1ps

module bb3_norm (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  bb3_pkg::sums_t                   sums_i,
  input  bb3_pkg::div_e                    div_i,
  input  bb3_pkg::pos_t                    pos_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bb3_pkg::PIX_W-1:0]        pixel_out_o,
  output logic [bb3_pkg::OUT_COORD_W-1:0]  out_col_o,
  output logic [bb3_pkg::OUT_COORD_W-1:0]  out_row_o,
  output logic                             frame_last_o
);

  import bb3_pkg::*;

  logic                         s3_valid_q, s3_valid_d;
  sums_t                        s3_sums_q;
  div_e                         s3_div_q;
  logic [OUT_COORD_W-1:0]       s3_col_q, s3_row_q;
  logic                         s3_last_q;
  logic                         out_valid_q, out_valid_d;
  logic [PIX_W-1:0]             pixel_q;
  logic [OUT_COORD_W-1:0]       col_q, row_q;
  logic                         last_q;
  logic                         out_free, s3_free, load3, load_out;
  logic [RECIP_W-1:0]           rcp;
  logic [SUM_W+RECIP_W-1:0]     prod [3];
  logic [CH_W-1:0]              quo [3];

  assign out_free = !out_valid_q || out_ready_i;
  assign s3_free  = !s3_valid_q || out_free;
  assign ready_o  = s3_free;
  assign load3    = valid_i && s3_free;
  assign load_out = s3_valid_q && out_free;

  // Hold the sums and position
  always_ff @(posedge clk_i) begin
    if (load3) begin
      s3_sums_q <= sums_i;
      s3_div_q  <= div_i;
      s3_col_q  <= pos_i.col;
      s3_row_q  <= pos_i.row;
      s3_last_q <= pos_i.last;
    end
  end

  // Divide by multiplying with the scaled reciprocal
  assign rcp = recip(s3_div_q);
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = (SUM_W+RECIP_W)'(s3_sums_q[ch]) * (SUM_W+RECIP_W)'(rcp);
      quo[ch]  = prod[ch][RECIP_SH +: CH_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pixel_q <= {quo[2], quo[1], quo[0], ALPHA_OPAQUE};
      col_q   <= s3_col_q;
      row_q   <= s3_row_q;
      last_q  <= s3_last_q;
    end
  end

  // Stage occupancy
  always_comb begin
    s3_valid_d = s3_valid_q;
    if (load3) begin
      s3_valid_d = 1'b1;
    end else if (load_out) begin
      s3_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s3_valid_q  <= s3_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pixel_q;
  assign out_col_o    = col_q;
  assign out_row_o    = row_q;
  assign frame_last_o = last_q;

  a_last_is_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && s3_last_q |-> s3_div_q == DIV4)
    else $error("final pixel of frame not averaged as a corner");

endmodule

// ===== rtl/box_blur_3x3_rgb.sv =====
`timescale 1ns / 1ps
// Path: a completing item is registered in stage 1, stage 2 and the norm hold stage, its result in the output register.
// Throughput: one item per cycle unless the output stalls; each line store has one read and one write port.
// The blurred pixel of raster index k is carried by item k+W+1; W+1 flush ticks drain a frame.
// Reset: raster position cleared, window cleared, width 800 and height 600.
// Line stores are not cleared: entries are only read where the window masks them off.

module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             kind_i,
  input  logic [bb3_pkg::PIX_W-1:0]        pixel_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bb3_pkg::PIX_W-1:0]        pixel_out_o,
  output logic [bb3_pkg::OUT_COORD_W-1:0]  out_col_o,
  output logic [bb3_pkg::OUT_COORD_W-1:0]  out_row_o,
  output logic                             frame_last_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bb3_pkg::PADDR_W-1:0]      paddr,
  input  logic [bb3_pkg::PDATA_W-1:0]      pwdata,
  output logic [bb3_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  import bb3_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int DIM_W  = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);

  logic              restart;
  logic [DIM_W-1:0]  width_use;
  logic [HDIM_W-1:0] height_use;
  logic              accept, process, rd_en;
  logic [COL_W-1:0]  scan_col;
  pos_t              scan_pos;
  logic [RGB_W-1:0]  bot;
  logic [RGB_W-1:0]  top_rd, mid_rd;

  logic              s1_valid_q, s1_valid_d;
  logic [RGB_W-1:0]  s1_bot_q;
  logic [COL_W-1:0]  s1_addr_q;
  pos_t              s1_pos_q;
  logic              s2_valid_q, s2_valid_d;
  pos_t              s2_pos_q;
  logic              s1_move, s2_free, s3_ready;
  sums_t             win_sums;
  div_e              win_div;

  bb3_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .restart_o (restart),
    .width_o   (width_use),
    .height_o  (height_use)
  );

  // Front end: one item per cycle while the first stage can move on
  assign s2_free    = !s2_valid_q || s3_ready;
  assign s1_move    = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s2_free;
  assign accept     = in_valid_i && in_ready_o;
  assign rd_en      = accept && process;
  assign bot        = kind_i ? '0 : pixel_in_i[PIX_W-1 -: RGB_W];

  bb3_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .step_i    (accept),
    .kind_i    (kind_i),
    .width_i   (width_use),
    .height_i  (height_use),
    .process_o (process),
    .col_o     (scan_col),
    .pos_o     (scan_pos)
  );

  // Line stores: two rows above and one row above the input row
  bb3_ram #(
    .WIDTH (RGB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_a (
    .clk_i   (clk_i),
    .we_i    (s1_move),
    .waddr_i (s1_addr_q),
    .wdata_i (mid_rd),
    .re_i    (rd_en),
    .raddr_i (scan_col),
    .rdata_o (top_rd)
  );

  bb3_ram #(
    .WIDTH (RGB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_b (
    .clk_i   (clk_i),
    .we_i    (s1_move),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_bot_q),
    .re_i    (rd_en),
    .raddr_i (scan_col),
    .rdata_o (mid_rd)
  );

  // Stage 1: wait for the line store read
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_bot_q  <= bot;
      s1_addr_q <= scan_col;
      s1_pos_q  <= scan_pos;
    end
  end

  // Stage 2: window shifted, carry the position if a result is due
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_pos_q <= s1_pos_q;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (rd_en) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s1_move) begin
      s2_valid_d = s1_pos_q.produce;
    end else if (s3_ready) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  bb3_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_move),
    .top_i   (top_rd),
    .mid_i   (mid_rd),
    .bot_i   (s1_bot_q),
    .pos_i   (s2_pos_q),
    .sums_o  (win_sums),
    .div_o   (win_div)
  );

  bb3_norm u_norm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s2_valid_q),
    .ready_o      (s3_ready),
    .sums_i       (win_sums),
    .div_i        (win_div),
    .pos_i        (s2_pos_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_out_o  (pixel_out_o),
    .out_col_o    (out_col_o),
    .out_row_o    (out_row_o),
    .frame_last_o (frame_last_o)
  );

  a_empty_front_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with an empty first stage");

endmodule

// ===== test/box_blur_3x3_rgb_tb.sv =====
`timescale 1ns / 1ps

module box_blur_3x3_rgb_tb;
  import bb3_pkg::*;

  localparam int unsigned MAX_DIM        = 1024;
  localparam int unsigned RANDOM_ITEMS   = 300;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned END_CYCLES     = 20;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int          DIR_ROWS       = 24;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0]       pixel;
    logic [OUT_COORD_W-1:0] col;
    logic [OUT_COORD_W-1:0] row;
    logic                   last;
  } blur_res_t;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pix;
    bit               pinned;
    blur_res_t        res;
  } dir_row_t;

  localparam blur_res_t NO_RES = '0;

  // Block ports
  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid;
  logic                   in_ready;
  logic                   kind;
  logic [PIX_W-1:0]       pixel_in;
  logic                   out_valid;
  logic                   out_ready;
  logic [PIX_W-1:0]       pixel_out;
  logic [OUT_COORD_W-1:0] out_col;
  logic [OUT_COORD_W-1:0] out_row;
  logic                   frame_last;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [PDATA_W-1:0]     pwdata;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  // Result typed in by the directed table for the item on the bus
  bit        pinned_exp;
  blur_res_t pinned_res;

  // Blur state as the block should hold it
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [RGB_W-1:0] row_two_up [MAX_DIM];
  logic [RGB_W-1:0] row_one_up [MAX_DIM];
  logic [RGB_W-1:0] win [9];
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      taken_cnt;

  blur_res_t   blurred_q [$];
  blur_res_t   pred_res;
  blur_res_t   want_res;
  bit          pred_made;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned stream_items;
  int          in_calm;
  int          out_calm;
  dir_row_t    directed_rows [DIR_ROWS];

  box_blur_3x3_rgb i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .kind_i       (kind),
    .pixel_in_i   (pixel_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .pixel_out_o  (pixel_out),
    .out_col_o    (out_col),
    .out_row_o    (out_row),
    .frame_last_o (frame_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Saturate a programmed dimension to the range in use
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Wait before the next item: mostly short, sometimes long, with calm stretches
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(16, 64);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 1);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] p;
    logic [3:0]       m;
    p = $urandom();
    // Saturated channels now and then
    if ($urandom_range(0, 3) == 0) begin
      m = 4'($urandom());
      for (int b = 0; b < 4; b++) p[b*8 +: 8] = m[b] ? 8'hFF : 8'h00;
    end
    return p;
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim(input int unsigned typ_hi,
                                                input int unsigned wide_hi);
    case ($urandom_range(0, 9))
      0:       return CFG_W'($urandom_range(0, 1));
      1:       return CFG_W'($urandom_range(typ_hi + 1, wide_hi));
      default: return CFG_W'($urandom_range(2, typ_hi));
    endcase
  endfunction

  task automatic restart_frame();
    col_pos   = 0;
    row_pos   = 0;
    taken_cnt = 0;
  endtask

  // Advance the expected blur state by one accepted item
  task automatic blur_advance(input logic k_in, input logic [PIX_W-1:0] pix,
                              output bit made, output blur_res_t res);
    int unsigned w, h, total, c, ocol, orow, n, rlo, rhi, clo, chi, sum, idx;
    logic [RGB_W-1:0] top, mid, bot;
    made = 1'b0;
    res  = NO_RES;
    w     = clamp_dim(width_reg);
    h     = clamp_dim(height_reg);
    total = w * h;
    // Drop pixels during the drain and flushes outside it
    if (k_in == KIND_PIXEL && taken_cnt >= total) return;
    if (k_in == KIND_FLUSH && taken_cnt < total) return;

    c   = col_pos % MAX_DIM;
    bot = (k_in == KIND_PIXEL) ? pix[PIX_W-1:CH_W] : '0;
    top = row_two_up[c];
    mid = row_one_up[c];
    row_two_up[c] = mid;
    row_one_up[c] = bot;
    for (int r = 0; r < 3; r++) begin
      win[r*3]     = win[r*3 + 1];
      win[r*3 + 1] = win[r*3 + 2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = bot;

    if (taken_cnt >= w + 1) begin
      if (col_pos == 0) begin
        ocol = w - 1;
        orow = row_pos - 2;
      end else begin
        ocol = col_pos - 1;
        orow = row_pos - 1;
      end
      // Mask off window rows and columns outside the frame
      rlo = (orow > 0) ? 0 : 1;
      rhi = (orow < h - 1) ? 2 : 1;
      clo = (ocol > 0) ? 0 : 1;
      chi = (ocol < w - 1) ? 2 : 1;
      n   = (rhi - rlo + 1) * (chi - clo + 1);
      res.pixel[CH_W-1:0] = ALPHA_OPAQUE;
      for (int ch = 0; ch < 3; ch++) begin
        sum = 0;
        for (int rr = rlo; rr <= rhi; rr++)
          for (int cc = clo; cc <= chi; cc++) begin
            idx = rr * 3 + cc;
            sum += win[idx][ch*CH_W +: CH_W];
          end
        res.pixel[ch*CH_W + CH_W +: CH_W] = CH_W'(sum / n);
      end
      res.col  = ocol[OUT_COORD_W-1:0];
      res.row  = orow[OUT_COORD_W-1:0];
      res.last = (taken_cnt - w - 1 == total - 1);
      made     = 1'b1;
      if (res.last) begin
        restart_frame();
        return;
      end
    end

    taken_cnt++;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Predict on accepted items, check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        blur_advance(kind, pixel_in, pred_made, pred_res);
        if (pinned_exp) blurred_q.push_back(pinned_res);
        else if (pred_made) blurred_q.push_back(pred_res);
      end
      if (out_valid && out_ready) begin
        if (blurred_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got pixel 0x%0h col %0d row %0d",
                   $time, pixel_out, out_col, out_row);
          mismatches++;
        end else begin
          want_res = blurred_q.pop_front();
          check_field("pixel_out", want_res.pixel, pixel_out);
          check_field("out_col", 32'(want_res.col), 32'(out_col));
          check_field("out_row", 32'(want_res.row), 32'(out_row));
          check_field("frame_last", 32'(want_res.last), 32'(frame_last));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // End the run when nothing moves for too long
  initial begin
    wait (rst_ni === 1'b1);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: stall at random before each item
  initial begin
    int gap;
    out_ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = draw_wait(out_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // Present one item and hold it until accepted
  task automatic send_item(input logic k_in, input logic [PIX_W-1:0] pix,
                           input bit pinned, input blur_res_t res);
    int gap;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    kind       <= k_in;
    pixel_in   <= pix;
    pinned_exp <= pinned;
    pinned_res <= res;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Send the first cut items of a frame, with ignored items mixed in
  task automatic send_frame(input int unsigned w, input int unsigned h,
                            input int unsigned cut);
    int unsigned npix;
    npix = w * h;
    for (int unsigned i = 0; i < cut; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item((i < npix) ? KIND_FLUSH : KIND_PIXEL, rand_pixel(), 1'b0, NO_RES);
      send_item((i < npix) ? KIND_PIXEL : KIND_FLUSH, rand_pixel(), 1'b0, NO_RES);
      stream_items++;
    end
  endtask

  // Drop valid and wait until every result is in and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    // Let the predictor take the last accepted item first
    @(posedge clk_i);
    while (blurred_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [CFG_W-1:0] value);
    logic [PADDR_W-1:0] addr;
    logic [PDATA_W-1:0] data;
    addr = '0;
    addr[REG_IDX_BIT] = idx;
    // Junk in the unused upper bits now and then
    data = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
    data[CFG_W-1:0] = value;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field("pready", 32'd1, 32'(pready));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = value;
    else height_reg = value;
    restart_frame();
  endtask

  task automatic apb_check(input reg_idx_e idx, input logic [CFG_W-1:0] want);
    logic [PADDR_W-1:0] addr;
    addr = '0;
    addr[REG_IDX_BIT] = idx;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field("prdata", 32'(want), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv);
    apb_write(REG_FRAME_WIDTH, wv);
    apb_write(REG_FRAME_HEIGHT, hv);
    apb_check(REG_FRAME_WIDTH, wv);
    apb_check(REG_FRAME_HEIGHT, hv);
  endtask

  initial begin
    logic [CFG_W-1:0] wv, hv;
    int unsigned      w, h, nf, full, cut;

    rst_ni     <= 1'b0;
    in_valid   <= 1'b0;
    kind       <= KIND_PIXEL;
    pixel_in   <= '0;
    pinned_exp <= 1'b0;
    pinned_res <= NO_RES;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    mismatches   = 0;
    quiet_cycles = 0;
    stream_items = 0;
    in_calm      = 0;
    out_calm     = 0;

    // Reset state of the blur
    width_reg  = 11'd800;
    height_reg = 11'd600;
    for (int i = 0; i < MAX_DIM; i++) begin
      row_two_up[i] = '0;
      row_one_up[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    restart_frame();

    // 2x2 frames: every pixel is a corner, so each result is the mean of all four
    directed_rows = '{
      {KIND_FLUSH, 32'hDEADBEEF, 1'b0, NO_RES},  // flush outside the drain
      {KIND_PIXEL, 32'hFFFFFFFF, 1'b0, NO_RES},
      {KIND_PIXEL, 32'hFFFFFF00, 1'b0, NO_RES},  // alpha ignored
      {KIND_PIXEL, 32'hFFFFFFFF, 1'b0, NO_RES},
      {KIND_PIXEL, 32'hFFFFFFFF, 1'b1, {32'hFFFFFFFF, 10'd0, 10'd0, 1'b0}},
      {KIND_PIXEL, 32'h12345678, 1'b0, NO_RES},  // pixel during the drain
      {KIND_FLUSH, 32'h00000000, 1'b1, {32'hFFFFFFFF, 10'd1, 10'd0, 1'b0}},
      {KIND_FLUSH, 32'h00000000, 1'b1, {32'hFFFFFFFF, 10'd0, 10'd1, 1'b0}},
      {KIND_FLUSH, 32'h00000000, 1'b1, {32'hFFFFFFFF, 10'd1, 10'd1, 1'b1}},
      {KIND_PIXEL, 32'h00000000, 1'b0, NO_RES},
      {KIND_PIXEL, 32'h000000FF, 1'b0, NO_RES},
      {KIND_PIXEL, 32'h00000000, 1'b0, NO_RES},
      {KIND_PIXEL, 32'h00000000, 1'b1, {32'h000000FF, 10'd0, 10'd0, 1'b0}},
      {KIND_FLUSH, 32'hFFFFFFFF, 1'b1, {32'h000000FF, 10'd1, 10'd0, 1'b0}},
      {KIND_FLUSH, 32'hFFFFFFFF, 1'b1, {32'h000000FF, 10'd0, 10'd1, 1'b0}},
      {KIND_FLUSH, 32'hFFFFFFFF, 1'b1, {32'h000000FF, 10'd1, 10'd1, 1'b1}},
      {KIND_PIXEL, 32'hFF000000, 1'b0, NO_RES},
      {KIND_PIXEL, 32'h00FF0000, 1'b0, NO_RES},
      {KIND_PIXEL, 32'h0000FF00, 1'b0, NO_RES},
      {KIND_PIXEL, 32'h80808080, 1'b0, NO_RES},
      {KIND_FLUSH, 32'h00000000, 1'b0, NO_RES},
      {KIND_FLUSH, 32'h00000000, 1'b0, NO_RES},
      {KIND_FLUSH, 32'h00000000, 1'b0, NO_RES},
      {KIND_FLUSH, 32'h00000000, 1'b0, NO_RES}   // new frame: ignored again
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values of the registers
    apb_check(REG_FRAME_WIDTH, 11'd800);
    apb_check(REG_FRAME_HEIGHT, 11'd600);

    // Directed: dimensions below range saturate to 2x2
    set_dims(11'd0, 11'd1);
    for (int r = 0; r < DIR_ROWS; r++)
      send_item(directed_rows[r].kind, directed_rows[r].pix, directed_rows[r].pinned,
                directed_rows[r].res);

    // Widest frame, shortest height, cut short just past the first row wrap
    settle();
    set_dims(11'h7FF, 11'd2);
    send_frame(MAX_DIM, 2, MAX_DIM + 16);

    // Tallest frame, narrowest width, cut short by the next write
    settle();
    set_dims(11'd2, 11'd1024);
    send_frame(2, MAX_DIM, 40);

    // Random frames, mostly small, the last one of a phase sometimes cut short
    stream_items = 0;
    while (stream_items < RANDOM_ITEMS) begin
      settle();
      wv = pick_dim(12, 40);
      hv = pick_dim(8, 20);
      set_dims(wv, hv);
      w  = clamp_dim(wv);
      h  = clamp_dim(hv);
      nf = $urandom_range(1, 3);
      for (int f = 0; f < nf; f++) begin
        full = w * h + w + 1;
        cut  = (f == nf - 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, full - 1) : full;
        send_frame(w, h, cut);
      end
    end

    settle();
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
